### hw/rtl/min_heap_priority_queue_defines.svh
// Assertion macros for the min-heap priority queue checker.
// Needs a clk and an active-high rst in the scope where they are used.
`ifndef MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define HPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define HPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### hw/rtl/hpq_pkg.sv
// Shared types and codes for the min-heap priority queue.
// Used by hpq_cell, min_heap_priority_queue and hpq_check; depends on nothing.
package hpq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int PRIO_W = 16;
  localparam int TAG_W  = 16;

  // operation codes on the input word
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // status codes on the output word
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // two siblings stored side by side, left child in lo
  typedef struct packed {
    entry_t hi;
    entry_t lo;
  } pair_t;

  // sift token handed from one level cell to the next
  typedef struct packed {
    logic   valid;
    logic   op;
    logic   placed;
    entry_t x;
  } tok_t;

endpackage

### hw/rtl/hpq_cell.sv
// One heap level: the entries of that level, stored as sibling pairs,
// plus the compare-and-write step of a root-to-leaf sift. Uses hpq_pkg.
module hpq_cell #(
  parameter int CAPACITY = hpq_pkg::CAPACITY_DEF,
  parameter int LEVEL = 0,
  localparam int LEVELS = $clog2(CAPACITY + 1),
  localparam int OW = LEVELS - 1,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int DW = $clog2(LEVELS + 1)
) (
  input  logic            clk,
  input  logic            rst,
  // token from the level above and to the level below
  input  hpq_pkg::tok_t   tok_in,
  input  logic [OW-1:0]   off_in,
  output hpq_pkg::tok_t   tok_out,
  output logic [OW-1:0]   off_out,
  // parameters of the running pass
  input  logic [CW-1:0]   pass_cnt,
  input  logic [CW-1:0]   pass_m,
  input  logic [DW-1:0]   pass_d,
  // child pair read: request from the level above, request to the level below
  input  logic            up_rd_en,
  input  logic [OW-1:0]   up_rd_off,
  output logic            dn_rd_en,
  output logic [OW-1:0]   dn_rd_off,
  output hpq_pkg::pair_t  rd_pair,
  input  hpq_pkg::pair_t  dn_pair,
  // direct entry fetch from the controller
  input  logic            fetch_en,
  input  logic [DW-1:0]   fetch_lvl,
  input  logic [OW-1:0]   fetch_off,
  output logic            done
);

  localparam bit LAST = (LEVEL == LEVELS - 1);
  localparam int DEPTH = (LEVEL == 0) ? 1 : (1 << (LEVEL - 1));
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LBASE = (1 << (LEVEL + 1)) - 1;

  hpq_pkg::entry_t mem_lo [DEPTH];
  hpq_pkg::entry_t mem_hi [DEPTH];

  logic            busy;
  logic            busy_next;
  hpq_pkg::tok_t   hold;
  logic [OW-1:0]   hold_off;
  hpq_pkg::tok_t   tok_next;
  logic [OW-1:0]   off_next;
  logic            done_next;

  logic            wr_en;
  logic [OW-1:0]   wr_off;
  hpq_pkg::entry_t wr_data;
  logic [IW-1:0]   wr_idx;
  logic [IW-1:0]   rd_idx;
  logic            fetch_hit;

  logic            is_final_ins;
  logic [DW-1:0]   bsel;
  logic            path_bit;
  hpq_pkg::entry_t own_e;
  logic [CW:0]     lidx;
  logic            lv;
  logic            rv;
  logic            take_l;
  logic            take_r;
  logic [hpq_pkg::PRIO_W-1:0] best_l_prio;

  // insert path: final level, and the branch taken toward the target slot
  assign is_final_ins = (pass_d == DW'(LEVEL));
  assign bsel         = pass_d - DW'(LEVEL + 1);
  assign path_bit     = pass_m[bsel];
  assign own_e        = hold_off[0] ? rd_pair.hi : rd_pair.lo;

  // children of the hole, valid only below the entry count
  assign lidx        = (CW + 1)'(LBASE) + (CW + 1)'({hold_off, 1'b0});
  assign lv          = lidx < {1'b0, pass_cnt};
  assign rv          = (lidx + (CW + 1)'(1)) < {1'b0, pass_cnt};
  assign take_l      = lv && (dn_pair.lo.prio < hold.x.prio);
  assign best_l_prio = take_l ? dn_pair.lo.prio : hold.x.prio;
  assign take_r      = rv && (dn_pair.hi.prio < best_l_prio);

  // read port: neighbor request first, then fetch, then own path slot
  assign fetch_hit = fetch_en && (fetch_lvl == DW'(LEVEL));
  always_comb begin
    if (up_rd_en) begin
      rd_idx = IW'(up_rd_off);
    end else if (fetch_hit) begin
      rd_idx = IW'(fetch_off >> 1);
    end else begin
      rd_idx = IW'(off_in >> 1);
    end
  end
  assign wr_idx = IW'(wr_off >> 1);

  // sift step: read on token arrival, compare and write in the next cycle
  always_comb begin
    busy_next       = busy;
    tok_next        = tok_out;
    tok_next.valid  = 1'b0;
    off_next        = off_out;
    done_next       = 1'b0;
    wr_en           = 1'b0;
    wr_off          = off_in;
    wr_data         = tok_in.x;
    dn_rd_en        = 1'b0;
    dn_rd_off       = off_in;
    if (busy) begin
      busy_next = 1'b0;
      wr_off    = hold_off;
      wr_data   = hold.x;
      if (hold.op == hpq_pkg::OP_INSERT) begin
        tok_next.valid = 1'b1;
        tok_next.op    = hpq_pkg::OP_INSERT;
        off_next       = OW'({hold_off, path_bit});
        if (hold.placed || (hold.x.prio < own_e.prio)) begin
          // new entry (or the one pushed down) takes this slot
          wr_en           = 1'b1;
          tok_next.placed = 1'b1;
          tok_next.x      = own_e;
        end else begin
          tok_next.placed = 1'b0;
          tok_next.x      = hold.x;
        end
      end else begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_data         = dn_pair.hi;
          tok_next.valid  = 1'b1;
          tok_next.op     = hpq_pkg::OP_EXTRACT;
          tok_next.placed = 1'b0;
          tok_next.x      = hold.x;
          off_next        = OW'({hold_off, 1'b1});
        end else if (take_l) begin
          wr_data         = dn_pair.lo;
          tok_next.valid  = 1'b1;
          tok_next.op     = hpq_pkg::OP_EXTRACT;
          tok_next.placed = 1'b0;
          tok_next.x      = hold.x;
          off_next        = OW'({hold_off, 1'b0});
        end else begin
          // carried entry settles in the hole
          done_next = 1'b1;
        end
      end
    end else if (tok_in.valid) begin
      if (tok_in.op == hpq_pkg::OP_INSERT) begin
        if (is_final_ins) begin
          wr_en     = 1'b1;
          done_next = 1'b1;
        end else begin
          busy_next = 1'b1;
        end
      end else begin
        if (LAST) begin
          wr_en     = 1'b1;
          done_next = 1'b1;
        end else begin
          dn_rd_en  = 1'b1;
          busy_next = 1'b1;
        end
      end
    end
  end

  // control and token registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      tok_out.valid <= 1'b0;
      done          <= 1'b0;
    end else begin
      busy    <= busy_next;
      tok_out <= tok_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    off_out <= off_next;
    if (!busy && tok_in.valid) begin
      hold     <= tok_in;
      hold_off <= off_in;
    end
  end

  // level storage, one write and one registered pair read per cycle
  always_ff @(posedge clk) begin
    if (wr_en && !wr_off[0]) begin
      mem_lo[wr_idx] <= wr_data;
    end
    if (wr_en && wr_off[0]) begin
      mem_hi[wr_idx] <= wr_data;
    end
    rd_pair.lo <= mem_lo[rd_idx];
    rd_pair.hi <= mem_hi[rd_idx];
  end

endmodule

### hw/rtl/min_heap_priority_queue.sv
// Binary min-heap priority queue of CAPACITY entries (16-bit priority, 16-bit tag),
// built as a chain of level cells, one per heap level, each with its own small
// memory. An insert walks from the root down the path to the first free slot,
// pushing larger entries one level down; an extract returns the root, moves the
// last entry to the root and sifts it down level by level. Each cell handles its
// level in two steps, a memory read and then a compare and write; an insert's final
// level and the last level of an extract only write. A rejected word (insert when
// full, extract when empty) goes straight to the response state. One word is worked
// on at a time; a finished result sits in the output register while the next word
// is taken. The store needs no clearing after reset. Uses hpq_pkg and hpq_cell.
module min_heap_priority_queue #(
  parameter int CAPACITY = hpq_pkg::CAPACITY_DEF,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int MDW = ((hpq_pkg::PRIO_W + hpq_pkg::TAG_W + CW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [31:0]    s_tdata,   // priority_req [15:0], sender_tag [31:16]
  input  logic [0:0]     s_tuser,   // opcode [0]
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [MDW-1:0] m_tdata,   // out_priority, out_tag, entry_count_out, zero fill
  output logic [1:0]     m_tuser    // status [1:0]
);

  localparam int LEVELS = $clog2(CAPACITY + 1);
  localparam int OW = LEVELS - 1;
  localparam int DW = $clog2(LEVELS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROOT = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]      state;
  logic [CW-1:0]   cnt;
  logic [DW-1:0]   lvl;
  logic [CW-1:0]   pass_cnt;
  logic [CW-1:0]   pass_m;
  logic [DW-1:0]   pass_d;
  logic [DW-1:0]   f_lvl;
  logic [OW-1:0]   f_off;
  hpq_pkg::tok_t   tok0;
  logic [1:0]      res_status;
  logic [hpq_pkg::PRIO_W-1:0] res_prio;
  logic [hpq_pkg::TAG_W-1:0]  res_tag;

  logic            accept;
  logic            op;
  hpq_pkg::entry_t in_e;
  logic [CW:0]     cnt_p1;
  logic [CW:0]     cnt_p2;
  logic            p1_pow2;
  logic            p2_pow2;
  logic            is_full;
  logic [DW-1:0]   last_lvl;
  logic [OW-1:0]   last_off;
  logic            fetch_en;
  logic [DW-1:0]   fetch_lvl;
  logic [OW-1:0]   fetch_off;
  hpq_pkg::pair_t  sel_pair;
  hpq_pkg::entry_t last_e;

  hpq_pkg::tok_t   tok       [LEVELS+1];
  logic [OW-1:0]   toff      [LEVELS+1];
  logic            rdreq_en  [LEVELS+1];
  logic [OW-1:0]   rdreq_off [LEVELS+1];
  hpq_pkg::pair_t  pair      [LEVELS+1];
  logic [LEVELS-1:0] done_v;

  // input word
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign op       = s_tuser[0];
  assign in_e.prio = s_tdata[hpq_pkg::PRIO_W-1:0];
  assign in_e.tag  = s_tdata[hpq_pkg::PRIO_W +: hpq_pkg::TAG_W];

  // depth bookkeeping: lvl is floor(log2(cnt + 1)), the depth of the next free slot
  assign cnt_p1   = {1'b0, cnt} + (CW + 1)'(1);
  assign cnt_p2   = {1'b0, cnt} + (CW + 1)'(2);
  assign p1_pow2  = (cnt_p1 & (cnt_p1 - (CW + 1)'(1))) == '0;
  assign p2_pow2  = (cnt_p2 & (cnt_p2 - (CW + 1)'(1))) == '0;
  assign is_full  = (cnt == CW'(CAPACITY));
  assign last_lvl = lvl - DW'(p1_pow2);
  assign last_off = OW'(cnt - (CW'(1) << last_lvl));

  // fetch of the root on accept, then of the last entry
  assign fetch_en  = (accept && (op == hpq_pkg::OP_EXTRACT) && (cnt != '0))
                     || (state == S_ROOT);
  assign fetch_lvl = (state == S_ROOT) ? f_lvl : '0;
  assign fetch_off = (state == S_ROOT) ? f_off : '0;
  assign sel_pair  = pair[f_lvl];
  assign last_e    = f_off[0] ? sel_pair.hi : sel_pair.lo;

  // chain ends
  assign tok[0]       = tok0;
  assign toff[0]      = '0;
  assign rdreq_en[0]  = 1'b0;
  assign rdreq_off[0] = '0;
  assign pair[LEVELS] = '0;

  // one cell per heap level
  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    hpq_cell #(
      .CAPACITY (CAPACITY),
      .LEVEL    (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .tok_in    (tok[k]),
      .off_in    (toff[k]),
      .tok_out   (tok[k+1]),
      .off_out   (toff[k+1]),
      .pass_cnt  (pass_cnt),
      .pass_m    (pass_m),
      .pass_d    (pass_d),
      .up_rd_en  (rdreq_en[k]),
      .up_rd_off (rdreq_off[k]),
      .dn_rd_en  (rdreq_en[k+1]),
      .dn_rd_off (rdreq_off[k+1]),
      .rd_pair   (pair[k]),
      .dn_pair   (pair[k+1]),
      .fetch_en  (fetch_en),
      .fetch_lvl (fetch_lvl),
      .fetch_off (fetch_off),
      .done      (done_v[k])
    );
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      lvl        <= '0;
      tok0.valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // output word taken; the response state reloads the register itself
      if (m_tvalid && m_tready && (state != S_RESP)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_prio <= '0;
            res_tag  <= '0;
            if (op == hpq_pkg::OP_INSERT) begin
              if (is_full) begin
                res_status <= hpq_pkg::ST_FULL;
                state      <= S_RESP;
              end else begin
                cnt        <= CW'(cnt_p1);
                lvl        <= lvl + DW'(p2_pow2);
                pass_cnt   <= CW'(cnt_p1);
                pass_m     <= CW'(cnt_p1);
                pass_d     <= lvl;
                tok0       <= '{valid: 1'b1, op: hpq_pkg::OP_INSERT, placed: 1'b0, x: in_e};
                res_status <= hpq_pkg::ST_OK;
                state      <= S_RUN;
              end
            end else begin
              if (cnt == '0) begin
                res_status <= hpq_pkg::ST_EMPTY;
                state      <= S_RESP;
              end else begin
                cnt        <= cnt - CW'(1);
                lvl        <= last_lvl;
                pass_cnt   <= cnt - CW'(1);
                f_lvl      <= last_lvl;
                f_off      <= last_off;
                res_status <= hpq_pkg::ST_OK;
                state      <= S_ROOT;
              end
            end
          end
        end
        S_ROOT: begin
          res_prio <= pair[0].lo.prio;
          res_tag  <= pair[0].lo.tag;
          state    <= S_LAST;
        end
        S_LAST: begin
          if (pass_cnt == '0) begin
            state <= S_RESP;
          end else begin
            tok0  <= '{valid: 1'b1, op: hpq_pkg::OP_EXTRACT, placed: 1'b0, x: last_e};
            state <= S_RUN;
          end
        end
        S_RUN: begin
          // the root cell takes the token when the pass begins
          tok0.valid <= 1'b0;
          if (|done_v) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= MDW'({cnt, res_tag, res_prio});
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/hpq_check.sv
// Port-level checks for min_heap_priority_queue, attached by bind.
// Uses hpq_pkg and the macros of min_heap_priority_queue_defines.svh.
`include "min_heap_priority_queue_defines.svh"

module hpq_check #(
  parameter int CAPACITY = hpq_pkg::CAPACITY_DEF,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int MDW = ((hpq_pkg::PRIO_W + hpq_pkg::TAG_W + CW + 7) / 8) * 8
) (
  input logic           clk,
  input logic           rst,
  input logic           s_tvalid,
  input logic           s_tready,
  input logic           m_tvalid,
  input logic           m_tready,
  input logic [MDW-1:0] m_tdata,
  input logic [1:0]     m_tuser
);

  localparam int CNT_LO = hpq_pkg::PRIO_W + hpq_pkg::TAG_W;

  // a stalled result word holds
  `HPQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // the count never exceeds the capacity
  `HPQ_ASSERT_NOW(a_cnt_range, m_tvalid, m_tdata[CNT_LO +: CW] <= CW'(CAPACITY))

  // an empty answer carries no entry and a zero count
  `HPQ_ASSERT_NOW(a_empty_word, m_tvalid && m_tuser == hpq_pkg::ST_EMPTY, m_tdata[CNT_LO +: CW] == '0 && m_tdata[CNT_LO-1:0] == '0)

  // a full answer carries no entry and a count at capacity
  `HPQ_ASSERT_NOW(a_full_word, m_tvalid && m_tuser == hpq_pkg::ST_FULL, m_tdata[CNT_LO +: CW] == CW'(CAPACITY) && m_tdata[CNT_LO-1:0] == '0)

  // one word in flight: input closes right after a word is taken
  `HPQ_ASSERT_NEXT(a_one_word, s_tvalid && s_tready, !s_tready)

endmodule

bind min_heap_priority_queue hpq_check #(
  .CAPACITY (CAPACITY)
) u_hpq_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
